// File: hw/rtl/p3rsc_pkg.sv
// ============================================================================
// p3rsc_pkg
// Shared types and constants for the POP3 response stream checker.
// ============================================================================
`default_nettype none

package p3rsc_pkg;

    // Segment parsing phase
    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_PLUS     = 3'd1,
        PH_MINUS    = 3'd2,
        PH_LINE_OK  = 3'd3,
        PH_LINE_ERR = 3'd4,
        PH_CONT     = 3'd5,
        PH_BODY     = 3'd6,
        PH_DONE     = 3'd7
    } phase_t;

    // Verdict codes
    localparam logic [1:0] VERDICT_CHECKING = 2'd0;
    localparam logic [1:0] VERDICT_FAILED   = 2'd1;
    localparam logic [1:0] VERDICT_DETECTED = 2'd2;

    // Dot-line tracking codes
    localparam logic [1:0] DOT_LINE_START = 2'd0;
    localparam logic [1:0] DOT_ONLY       = 2'd1;
    localparam logic [1:0] DOT_OTHER      = 2'd2;

    // Byte position marks
    localparam logic [2:0] POS_ERR_CHECK = 3'd4;
    localparam logic [2:0] POS_SAT       = 3'd5;

    // Characters
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_O        = 8'h4F;
    localparam logic [7:0] CH_K        = 8'h4B;
    localparam logic [7:0] CH_E        = 8'h45;
    localparam logic [7:0] CH_R        = 8'h52;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;

    localparam logic [7:0] THRESHOLD_RESET = 8'd4;

    // Per-segment parse state
    typedef struct packed {
        phase_t     phase;
        logic [2:0] pos;
        logic [1:0] dot;
        logic       failed;
        logic       cr;
    } seg_t;

    // Session-wide flags
    typedef struct packed {
        logic multi;
        logic seen_first;
        logic err;
        logic det;
    } ses_t;

    // One result transfer
    typedef struct packed {
        logic [1:0] verdict;
        logic [7:0] response_count;
        logic       last_was_error;
    } res_t;

    localparam seg_t SEG_CLEAR = '{
        phase:  PH_START,
        pos:    3'd0,
        dot:    DOT_LINE_START,
        failed: 1'b0,
        cr:     1'b0
    };

    localparam ses_t SES_CLEAR = '{
        multi:      1'b0,
        seen_first: 1'b0,
        err:        1'b0,
        det:        1'b0
    };

endpackage

`default_nettype wire

// File: hw/rtl/p3rsc_in_if.sv
// ============================================================================
// p3rsc_in_if
// Byte stream channel: one payload byte with segment marks.
// ============================================================================
`default_nettype none

interface p3rsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       first_of_segment;
    logic       last_of_segment;

    modport source (
        output valid,
        output byte_value,
        output first_of_segment,
        output last_of_segment,
        input  ready
    );

    modport sink (
        input  valid,
        input  byte_value,
        input  first_of_segment,
        input  last_of_segment,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/p3rsc_out_if.sv
// ============================================================================
// p3rsc_out_if
// Result channel: per-segment verdict, response count and error flag.
// ============================================================================
`default_nettype none

interface p3rsc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [7:0] response_count;
    logic       last_was_error;

    modport source (
        output valid,
        output verdict,
        output response_count,
        output last_was_error,
        input  ready
    );

    modport sink (
        input  valid,
        input  verdict,
        input  response_count,
        input  last_was_error,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/p3rsc_step.sv
// ============================================================================
// p3rsc_step
// Next-state and result logic for one byte of the response stream.
// ============================================================================
`default_nettype none

module p3rsc_step #(
    parameter int unsigned COUNT_MAX = 255,
    parameter int unsigned CW        = 8
) (
    input  var p3rsc_pkg::seg_t cur_seg,
    input  var p3rsc_pkg::ses_t cur_ses,
    input  wire logic [CW-1:0]  cur_count,
    input  wire logic [7:0]     byte_value,
    input  wire logic           first_of_segment,
    input  wire logic           last_of_segment,
    input  wire logic [7:0]     threshold,
    output p3rsc_pkg::seg_t     nxt_seg,
    output p3rsc_pkg::ses_t     nxt_ses,
    output logic [CW-1:0]       nxt_count,
    output p3rsc_pkg::res_t     res
);
    import p3rsc_pkg::*;

    localparam int unsigned CMPW = (CW > 8) ? CW : 8;

    seg_t          s;
    seg_t          w;
    ses_t          ses;
    phase_t        ph;
    logic          printable;
    logic          sc_close;
    logic          sc_err;
    logic          sc_cr;
    logic [1:0]    sc_dot;
    logic          bump;
    logic [CW-1:0] cnt;
    logic [CW+7:0] cnt_ext;

    // Line scanner: CR LF framing and printable check
    always_comb
    begin
        s         = first_of_segment ? SEG_CLEAR : cur_seg;
        printable = byte_value inside {[CH_PRINT_LO:CH_PRINT_HI]};
        sc_close  = s.cr && (byte_value == CH_LF);
        sc_err    = s.cr ? (byte_value != CH_LF)
                         : ((byte_value != CH_CR) && !printable);
        sc_cr     = !s.cr && (byte_value == CH_CR);
        sc_dot    = s.dot;
        if (!s.cr && (byte_value != CH_CR) && printable)
        begin
            sc_dot = ((s.dot == DOT_LINE_START) && (byte_value == CH_DOT))
                     ? DOT_ONLY : DOT_OTHER;
        end
    end

    always_comb
    begin
        w    = s;
        ses  = cur_ses;
        bump = 1'b0;
        ph   = s.phase;

        // Take the error flag on the fifth byte of a status line
        if ((s.pos == POS_ERR_CHECK) && (s.phase inside {PH_LINE_OK, PH_LINE_ERR}))
        begin
            ses.err = (s.phase == PH_LINE_ERR);
        end

        if (!s.failed)
        begin
            if ((ph == PH_START) && cur_ses.multi)
            begin
                ph = PH_BODY;
            end
            w.phase = ph;
            case (ph)
                PH_START:
                begin
                    if (byte_value == CH_PLUS)
                        w.phase = PH_PLUS;
                    else if (byte_value == CH_MINUS)
                        w.phase = PH_MINUS;
                    else
                        w.failed = 1'b1;
                end
                PH_PLUS:
                begin
                    if ((s.pos == 3'd1) && (byte_value == CH_SPACE)
                        && cur_ses.seen_first && !cur_ses.multi)
                        w.phase = PH_CONT;
                    else if ((s.pos == 3'd1) && (byte_value == CH_O))
                        w.phase = PH_PLUS;
                    else if ((s.pos == 3'd2) && (byte_value == CH_K))
                        w.phase = PH_LINE_OK;
                    else
                        w.failed = 1'b1;
                end
                PH_MINUS:
                begin
                    if (((s.pos == 3'd1) && (byte_value == CH_E))
                        || ((s.pos == 3'd2) && (byte_value == CH_R)))
                        w.phase = PH_MINUS;
                    else if ((s.pos == 3'd3) && (byte_value == CH_R))
                        w.phase = PH_LINE_ERR;
                    else
                        w.failed = 1'b1;
                end
                PH_LINE_OK, PH_LINE_ERR:
                begin
                    w.cr  = sc_cr;
                    w.dot = sc_dot;
                    if (sc_err)
                    begin
                        w.failed = 1'b1;
                    end
                    else if (sc_close)
                    begin
                        w.dot = DOT_LINE_START;
                        if (last_of_segment)
                        begin
                            bump    = 1'b1;
                            w.phase = PH_DONE;
                        end
                        else
                        begin
                            ses.multi = 1'b1;
                            w.phase   = PH_BODY;
                        end
                    end
                end
                PH_CONT:
                begin
                    w.cr  = sc_cr;
                    w.dot = sc_dot;
                    if (sc_err || (sc_close && !last_of_segment))
                        w.failed = 1'b1;
                    else if (sc_close)
                        w.phase = PH_DONE;
                end
                PH_BODY:
                begin
                    w.cr  = sc_cr;
                    w.dot = sc_dot;
                    if (sc_err)
                    begin
                        w.failed = 1'b1;
                    end
                    else if (sc_close)
                    begin
                        w.dot = DOT_LINE_START;
                        if ((s.dot == DOT_ONLY) && last_of_segment)
                        begin
                            bump      = 1'b1;
                            ses.multi = 1'b0;
                            w.phase   = PH_DONE;
                        end
                    end
                end
                default:
                begin
                    w.phase = ph;
                end
            endcase
        end

        if (s.pos < POS_SAT)
        begin
            w.pos = s.pos + 3'd1;
        end

        // End-of-segment checks
        if (last_of_segment && !w.failed)
        begin
            case (w.phase)
                PH_LINE_OK, PH_LINE_ERR:
                begin
                    if (w.cr || (w.pos < POS_SAT))
                        w.failed = 1'b1;
                    else
                        bump = 1'b1;
                end
                PH_BODY:
                begin
                    if (w.cr)
                        w.failed = 1'b1;
                end
                PH_DONE:
                begin
                    w.failed = 1'b0;
                end
                default:
                begin
                    w.failed = 1'b1;
                end
            endcase
        end

        cnt = cur_count;
        if (bump && (cur_count < CW'(COUNT_MAX)))
        begin
            cnt = cur_count + CW'(1);
        end

        if (last_of_segment)
        begin
            if (!w.failed && (CMPW'(cnt) >= CMPW'(threshold)))
            begin
                ses.det = 1'b1;
            end
            ses.seen_first = 1'b1;
        end
    end

    assign cnt_ext   = {8'd0, cnt};
    assign nxt_count = cnt;
    assign nxt_ses   = ses;
    assign nxt_seg   = last_of_segment ? SEG_CLEAR : w;

    assign res.verdict        = ses.det  ? VERDICT_DETECTED
                              : (w.failed ? VERDICT_FAILED : VERDICT_CHECKING);
    assign res.response_count = cnt_ext[7:0];
    assign res.last_was_error = ses.err;

endmodule

`default_nettype wire

// File: hw/rtl/pop3_response_stream_checker_core.sv
// ============================================================================
// pop3_response_stream_checker_core
// Checks a server-to-client byte stream against the POP3 response grammar.
//
// Bytes arrive one per transfer on byte_stream, marked with the first and
// last byte of each segment. Every segment is checked for a +OK / -ERR
// status line (or a single "+ " continuation line after the first segment),
// printable lines closed by CR LF, and the "." line that closes a multi-line
// reply. One result transfer leaves on result for each byte marked as last
// of segment; other bytes give none. The block takes one byte per clock
// unless a byte that ends a segment waits on an undrained result register; a
// byte passes through the input register, then one pass of the per-byte state
// update writes its result into the result register. The rate is set by the
// single update loop over the session state. A full result register that is not being
// drained holds only a byte that ends a segment; other bytes keep flowing.
// threshold_reg (cfg_we / cfg_wdata, reset 4) sets how many completed
// responses declare the service detected; write it only while idle.
// ============================================================================
`default_nettype none

module pop3_response_stream_checker_core #(
    parameter int unsigned COUNT_MAX = 255
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    p3rsc_in_if.sink           byte_stream,
    p3rsc_out_if.source        result,
    input  wire logic          cfg_we,
    input  wire logic [7:0]    cfg_wdata
);
    import p3rsc_pkg::*;

    localparam int unsigned CW = $clog2(COUNT_MAX + 1);

    // Input register stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       in_last_reg;

    // Session and segment state
    seg_t          seg_reg;
    seg_t          seg_next;
    ses_t          ses_reg;
    ses_t          ses_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    threshold_reg;

    // Result register stage
    logic       out_valid_reg;
    res_t       out_reg;
    res_t       res_next;

    logic       in_xfer;
    logic       advance;

    // Advance the held byte unless it ends a segment and the result
    // register is still occupied by an untaken transfer.
    assign advance = in_valid_reg
                     && (!in_last_reg || !out_valid_reg || result.ready);
    assign byte_stream.ready = !in_valid_reg || advance;
    assign in_xfer = byte_stream.valid && byte_stream.ready;

    p3rsc_step #(
        .COUNT_MAX (COUNT_MAX),
        .CW        (CW)
    ) u_step (
        .cur_seg          (seg_reg),
        .cur_ses          (ses_reg),
        .cur_count        (count_reg),
        .byte_value       (in_byte_reg),
        .first_of_segment (in_first_reg),
        .last_of_segment  (in_last_reg),
        .threshold        (threshold_reg),
        .nxt_seg          (seg_next),
        .nxt_ses          (ses_next),
        .nxt_count        (count_next),
        .res              (res_next)
    );

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seg_reg       <= SEG_CLEAR;
            ses_reg       <= SES_CLEAR;
            count_reg     <= '0;
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                threshold_reg <= cfg_wdata;
            end

            if (in_xfer)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            // Commit the byte's state update as it leaves the input register
            if (advance)
            begin
                seg_reg   <= seg_next;
                ses_reg   <= ses_next;
                count_reg <= count_next;
            end

            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg  <= byte_stream.byte_value;
            in_first_reg <= byte_stream.first_of_segment;
            in_last_reg  <= byte_stream.last_of_segment;
        end
        if (advance && in_last_reg)
        begin
            out_reg <= res_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.verdict        = out_reg.verdict;
    assign result.response_count = out_reg.response_count;
    assign result.last_was_error = out_reg.last_was_error;

`ifndef ASSERT_OFF
    // Detection is sticky
    a_det_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ses_reg.det |=> ses_reg.det)
        else $error("detection flag cleared");

    // Response count never goes down
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg >= $past(count_reg)))
        else $error("response count decreased");

    // State moves only when a byte advances
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(count_reg) && $stable(seg_reg) && $stable(ses_reg)))
        else $error("state changed without a byte");

    // A held byte stays put until it advances
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)
                                        && $stable(in_last_reg)))
        else $error("held byte lost");

    // A detected verdict reflects the detection flag
    a_verdict_det: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=>
            ((out_reg.verdict == VERDICT_DETECTED) == ses_reg.det))
        else $error("verdict disagrees with detection flag");
`endif

endmodule

`default_nettype wire
